[sv/csv_field_tokenizer_with_stats_core_defines.svh]
// Assertion macros used by the tokenizer's port-level checker.
`ifndef CSV_FIELD_TOKENIZER_WITH_STATS_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_WITH_STATS_CORE_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define CSVT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define CSVT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/csvt_pkg.sv]
// Package: types, constants and codes of the CSV tokenizer.
package csvt_pkg;

    localparam int COUNT_BITS = 31;
    localparam int FIELD_W    = 31;
    localparam int PROD_W     = 2 * COUNT_BITS;
    localparam int SUM_W      = PROD_W + 1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [SUM_W-1:0]      sum_t;

    localparam count_t COUNT_LIMIT = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [3:0] {
        MODE_START      = 4'b0001,
        MODE_PLAIN      = 4'b0010,
        MODE_QUOTED     = 4'b0100,
        MODE_QUOTE_SEEN = 4'b1000
    } mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic               char_valid;
        logic [7:0]         char_out;
        logic               field_done;
        logic [FIELD_W-1:0] fld_len;
        logic               row_done;
        logic               end_done;
        logic               error;
        logic [FIELD_W-1:0] row_total;
        logic [FIELD_W-1:0] col_total;
        logic [FIELD_W-1:0] fld_total;
        logic [FIELD_W-1:0] byte_total;
    } out_word_t;

    // Parser result for one word, before the padding math.
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       field_done;
        count_t     fld_len;
        logic       row_done;
        logic       end_done;
        logic       fault;
        count_t     rows;
        count_t     widest;
        count_t     fields;
        count_t     text;
    } parse_rec_t;

    typedef struct packed {
        parse_rec_t base;
        prod_t      cells;
    } cells_rec_t;

endpackage

[sv/csvt_parser.sv]
// Parser state machine and running counters; yields one record per accepted word.
module csvt_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  csvt_pkg::in_word_t  word,
    output csvt_pkg::parse_rec_t rec
);

    csvt_pkg::mode_t  mode_reg, mode_next;
    logic             skip_lf_reg, skip_lf_next;
    csvt_pkg::count_t field_len_reg, field_len_next;
    csvt_pkg::count_t row_cols_reg, row_cols_next;
    csvt_pkg::count_t rows_reg, rows_next;
    csvt_pkg::count_t widest_reg, widest_next;
    csvt_pkg::count_t fields_reg, fields_next;
    csvt_pkg::count_t text_reg, text_next;
    logic             fault_reg, fault_next;

    logic [7:0] ch;
    logic       is_term;
    logic       do_append;
    logic       do_cf;
    logic       do_cr;
    logic       row_by_term;
    logic [csvt_pkg::COUNT_BITS:0] text_sum;
    csvt_pkg::count_t rc1;

    always_comb
    begin
        ch           = word.data_byte;
        is_term      = (ch == csvt_pkg::CH_CR) || (ch == csvt_pkg::CH_LF);
        do_append    = 1'b0;
        do_cf        = 1'b0;
        row_by_term  = 1'b0;
        mode_next    = mode_reg;
        skip_lf_next = skip_lf_reg;

        if (word.kind)
        begin
            do_cf = (mode_reg != csvt_pkg::MODE_START);
        end
        else if (skip_lf_reg && (ch == csvt_pkg::CH_LF))
        begin
            skip_lf_next = 1'b0;
        end
        else
        begin
            skip_lf_next = 1'b0;
            unique case (mode_reg)
                csvt_pkg::MODE_START:
                begin
                    if (is_term)
                        row_by_term = 1'b1;
                    else if (ch == csvt_pkg::CH_QUOTE)
                        mode_next = csvt_pkg::MODE_QUOTED;
                    else if (ch == csvt_pkg::CH_COMMA)
                        do_cf = 1'b1;
                    else
                    begin
                        mode_next = csvt_pkg::MODE_PLAIN;
                        do_append = 1'b1;
                    end
                end
                csvt_pkg::MODE_PLAIN:
                begin
                    if (is_term)
                        row_by_term = 1'b1;
                    else if (ch == csvt_pkg::CH_COMMA)
                    begin
                        do_cf     = 1'b1;
                        mode_next = csvt_pkg::MODE_START;
                    end
                    else
                        do_append = 1'b1;
                end
                csvt_pkg::MODE_QUOTED:
                begin
                    if (ch == csvt_pkg::CH_QUOTE)
                        mode_next = csvt_pkg::MODE_QUOTE_SEEN;
                    else
                        do_append = 1'b1;
                end
                csvt_pkg::MODE_QUOTE_SEEN:
                begin
                    if (is_term)
                        row_by_term = 1'b1;
                    else if (ch == csvt_pkg::CH_QUOTE)
                    begin
                        mode_next = csvt_pkg::MODE_QUOTED;
                        do_append = 1'b1;
                    end
                    else if (ch == csvt_pkg::CH_COMMA)
                    begin
                        do_cf     = 1'b1;
                        mode_next = csvt_pkg::MODE_START;
                    end
                    else
                    begin
                        mode_next = csvt_pkg::MODE_PLAIN;
                        do_append = 1'b1;
                    end
                end
                default:
                    mode_next = csvt_pkg::MODE_START;
            endcase
            if (row_by_term)
            begin
                do_cf        = 1'b1;
                mode_next    = csvt_pkg::MODE_START;
                skip_lf_next = (ch == csvt_pkg::CH_CR);
            end
        end

        // content byte
        rec            = '0;
        field_len_next = field_len_reg;
        fault_next     = fault_reg;
        if (do_append)
        begin
            if (field_len_reg == csvt_pkg::COUNT_LIMIT)
                fault_next = 1'b1;
            else
            begin
                field_len_next = field_len_reg + 1'b1;
                rec.char_valid = 1'b1;
                rec.char_out   = ch;
            end
        end

        // field close; sum carries out when the byte total would pass the limit
        text_sum    = {1'b0, text_reg} + {1'b0, field_len_reg} + 1'b1;
        rc1         = row_cols_reg;
        fields_next = fields_reg;
        text_next   = text_reg;
        if (do_cf)
        begin
            rec.field_done = 1'b1;
            rec.fld_len    = field_len_reg;
            field_len_next = '0;
            if ((fields_reg == csvt_pkg::COUNT_LIMIT) || text_sum[csvt_pkg::COUNT_BITS])
                fault_next = 1'b1;
            else
            begin
                rc1         = row_cols_reg + 1'b1;
                fields_next = fields_reg + 1'b1;
                text_next   = text_sum[csvt_pkg::COUNT_BITS-1:0];
            end
        end

        // row close
        do_cr         = word.kind ? (rc1 != '0) : row_by_term;
        row_cols_next = rc1;
        rows_next     = rows_reg;
        widest_next   = widest_reg;
        if (do_cr)
        begin
            rec.row_done  = 1'b1;
            row_cols_next = '0;
            if (rows_reg == csvt_pkg::COUNT_LIMIT)
                fault_next = 1'b1;
            else
            begin
                rows_next = rows_reg + 1'b1;
                if (rc1 > widest_reg)
                    widest_next = rc1;
            end
        end

        rec.fault = fault_next;
        if (word.kind)
        begin
            rec.end_done = 1'b1;
            rec.rows     = rows_next;
            rec.widest   = widest_next;
            rec.fields   = fields_next;
            rec.text     = text_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= csvt_pkg::MODE_START;
            skip_lf_reg   <= 1'b0;
            field_len_reg <= '0;
            row_cols_reg  <= '0;
            rows_reg      <= '0;
            widest_reg    <= '0;
            fields_reg    <= '0;
            text_reg      <= '0;
            fault_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (word.kind)
            begin
                mode_reg      <= csvt_pkg::MODE_START;
                skip_lf_reg   <= 1'b0;
                field_len_reg <= '0;
                row_cols_reg  <= '0;
                rows_reg      <= '0;
                widest_reg    <= '0;
                fields_reg    <= '0;
                text_reg      <= '0;
                fault_reg     <= 1'b0;
            end
            else
            begin
                mode_reg      <= mode_next;
                skip_lf_reg   <= skip_lf_next;
                field_len_reg <= field_len_next;
                row_cols_reg  <= row_cols_next;
                rows_reg      <= rows_next;
                widest_reg    <= widest_next;
                fields_reg    <= fields_next;
                text_reg      <= text_next;
                fault_reg     <= fault_next;
            end
        end
    end

endmodule

[sv/csvt_totals.sv]
// Cell-count multiply and padding stages feeding the result register.
module csvt_totals (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  a_valid,
    input  csvt_pkg::parse_rec_t  a_rec,
    output logic                  a_take,
    output logic                  result_valid,
    input  logic                  result_stall,
    output csvt_pkg::out_word_t   result
);

    logic                 b_valid_reg;
    csvt_pkg::cells_rec_t b_reg, b_next;
    logic                 c_valid_reg;
    csvt_pkg::out_word_t  c_reg, c_next;
    logic                 adv_b;
    logic                 adv_c;

    csvt_pkg::sum_t   lhs;
    csvt_pkg::sum_t   rhs;
    logic             pad_fault;
    csvt_pkg::prod_t  padded_total;
    csvt_pkg::count_t total;

    assign adv_c  = !c_valid_reg || !result_stall;
    assign adv_b  = !b_valid_reg || adv_c;
    assign a_take = adv_b;

    always_comb
    begin
        b_next.base  = a_rec;
        b_next.cells = csvt_pkg::PROD_W'(a_rec.rows) * csvt_pkg::PROD_W'(a_rec.widest);
    end

    // fields <= cells and cells - fields <= LIMIT - text
    always_comb
    begin
        lhs = csvt_pkg::SUM_W'(b_reg.cells) + csvt_pkg::SUM_W'(b_reg.base.text);
        rhs = csvt_pkg::SUM_W'(csvt_pkg::COUNT_LIMIT) + csvt_pkg::SUM_W'(b_reg.base.fields);
        pad_fault = b_reg.base.end_done &&
                    ((csvt_pkg::PROD_W'(b_reg.base.fields) > b_reg.cells) || (lhs > rhs));
        padded_total = b_reg.cells + csvt_pkg::PROD_W'(b_reg.base.text)
                     - csvt_pkg::PROD_W'(b_reg.base.fields);
        total = pad_fault ? b_reg.base.text : padded_total[csvt_pkg::COUNT_BITS-1:0];

        c_next.char_valid = b_reg.base.char_valid;
        c_next.char_out   = b_reg.base.char_out;
        c_next.field_done = b_reg.base.field_done;
        c_next.fld_len    = csvt_pkg::FIELD_W'(b_reg.base.fld_len);
        c_next.row_done   = b_reg.base.row_done;
        c_next.end_done   = b_reg.base.end_done;
        c_next.error      = b_reg.base.fault | pad_fault;
        c_next.row_total  = csvt_pkg::FIELD_W'(b_reg.base.rows);
        c_next.col_total  = csvt_pkg::FIELD_W'(b_reg.base.widest);
        c_next.fld_total  = csvt_pkg::FIELD_W'(b_reg.base.fields);
        c_next.byte_total = b_reg.base.end_done ? csvt_pkg::FIELD_W'(total) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_b)
                b_valid_reg <= a_valid;
            if (adv_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && a_valid)
            b_reg <= b_next;
        if (adv_c && b_valid_reg)
            c_reg <= c_next;
    end

    assign result_valid = c_valid_reg;
    assign result       = c_reg;

endmodule

[sv/csv_field_tokenizer_with_stats_core.sv]
// CSV field tokenizer with table statistics: one byte word in, one result word out,
// one word per clock sustained. Each data byte is parsed in the cycle it is accepted
// (field start / plain / quoted / quote-seen modes, doubled quotes, CR-LF folding) and
// its record is registered; the end-marker totals then take two more stages, one for
// the rows x widest-row multiply and one for the padding check and sum. A new word is
// taken every cycle unless result_stall backs up the three-stage pipe.
// After an end marker the counters are back at their reset values for the next buffer.
module csv_field_tokenizer_with_stats_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  csvt_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output csvt_pkg::out_word_t result
);

    logic                 take;
    logic                 a_take;
    logic                 a_valid_reg;
    csvt_pkg::parse_rec_t a_reg;
    csvt_pkg::parse_rec_t a_next;

    // stage A holds when the multiply stage cannot take it
    assign item_stall = a_valid_reg && !a_take;
    assign take       = item_valid && !item_stall;

    csvt_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (item),
        .rec   (a_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (!item_stall)
            a_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            a_reg <= a_next;
    end

    csvt_totals u_totals (
        .clk          (clk),
        .rst_n        (rst_n),
        .a_valid      (a_valid_reg),
        .a_rec        (a_reg),
        .a_take       (a_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sv/csvt_checker.sv]
// Port-level checker for the tokenizer, bound to the top level.
`include "csv_field_tokenizer_with_stats_core_defines.svh"

module csvt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input csvt_pkg::in_word_t  item,
    input logic                result_valid,
    input logic                result_stall,
    input csvt_pkg::out_word_t result
);

    logic in_held;
    logic out_held;
    logic stray_totals;
    logic end_char;
    logic char_close;

    assign in_held      = item_valid && item_stall;
    assign out_held     = result_valid && result_stall;
    assign stray_totals = result_valid && !result.end_done &&
                          ((result.row_total != '0) || (result.col_total != '0) ||
                           (result.fld_total != '0) || (result.byte_total != '0));
    assign end_char     = result_valid && result.end_done && result.char_valid;
    assign char_close   = result_valid && result.char_valid && result.field_done;

    // a stalled input word holds
    `CSVT_ASSERT(a_in_hold, in_held |=> (item_valid && $stable(item)), "stalled input changed")

    // a stalled result word holds
    `CSVT_ASSERT(a_hold, out_held |=> (result_valid && $stable(result)), "stalled result changed")

    // totals only appear with the end marker
    `CSVT_NEVER(a_totals, stray_totals, "totals on a non-end word")

    // the end marker never carries a content byte
    `CSVT_NEVER(a_end_char, end_char, "content byte on end word")

    // a byte is either appended or closes a field, never both
    `CSVT_NEVER(a_char_close, char_close, "byte appended and field closed together")

endmodule

bind csv_field_tokenizer_with_stats_core csvt_checker u_csvt_checker (.*);

[verif/csv_token_checker.sv]
// Result checker for the CSV tokenizer: predicts every result word and compares it.
module csv_token_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  csvt_pkg::in_word_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  csvt_pkg::out_word_t result,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);

    localparam logic [63:0] LIMIT = {33'd0, csvt_pkg::COUNT_LIMIT};

    // Tokenizer state, counters kept wide so overflow checks are exact.
    csvt_pkg::mode_t mode;
    logic            skip_lf;
    logic [63:0]     field_len;
    logic [63:0]     row_cols;
    logic [63:0]     rows;
    logic [63:0]     widest;
    logic [63:0]     fields;
    logic [63:0]     text_len;
    logic            fault;

    csvt_pkg::out_word_t word_now;      // result word being built for the current input word
    csvt_pkg::out_word_t want;
    csvt_pkg::out_word_t expected_words[$];

    function automatic void clear_state();
        mode      = csvt_pkg::MODE_START;
        skip_lf   = 1'b0;
        field_len = '0;
        row_cols  = '0;
        rows      = '0;
        widest    = '0;
        fields    = '0;
        text_len  = '0;
        fault     = 1'b0;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        if (field_len >= LIMIT)
        begin
            fault = 1'b1;
        end
        else
        begin
            field_len++;
            word_now.char_valid = 1'b1;
            word_now.char_out   = c;
        end
    endfunction

    function automatic void close_field();
        word_now.field_done = 1'b1;
        word_now.fld_len    = field_len[30:0];
        if (fields >= LIMIT || text_len + field_len + 64'd1 > LIMIT)
        begin
            fault = 1'b1;
        end
        else
        begin
            row_cols++;
            fields++;
            text_len = text_len + field_len + 64'd1;
        end
        field_len = '0;
    endfunction

    function automatic void close_row();
        word_now.row_done = 1'b1;
        if (rows >= LIMIT)
        begin
            fault = 1'b1;
        end
        else
        begin
            rows++;
            if (row_cols > widest)
                widest = row_cols;
        end
        row_cols = '0;
    endfunction

    function automatic void end_row(input logic [7:0] c);
        close_field();
        close_row();
        mode = csvt_pkg::MODE_START;
        if (c == csvt_pkg::CH_CR)
            skip_lf = 1'b1;
    endfunction

    // End marker: close what is open, pad to rows x widest, report totals.
    function automatic void finish_buffer();
        logic [63:0] cells;
        logic [63:0] padded;
        logic [63:0] total;
        if (mode != csvt_pkg::MODE_START)
            close_field();
        if (row_cols != 0)
            close_row();
        cells = rows * widest;
        total = text_len;
        if (fields > cells)
        begin
            fault = 1'b1;
        end
        else
        begin
            padded = cells - fields;
            if (padded > LIMIT - text_len)
                fault = 1'b1;
            else
                total = text_len + padded;
        end
        word_now.end_done   = 1'b1;
        word_now.row_total  = rows[30:0];
        word_now.col_total  = widest[30:0];
        word_now.fld_total  = fields[30:0];
        word_now.byte_total = total[30:0];
    endfunction

    function automatic void tokenize(input csvt_pkg::in_word_t w);
        logic [7:0] c;
        logic       term;
        c        = w.data_byte;
        word_now = '0;
        if (w.kind)
        begin
            finish_buffer();
            word_now.error = fault;
            clear_state();
            return;
        end
        if (skip_lf)
        begin
            skip_lf = 1'b0;
            if (c == csvt_pkg::CH_LF)
            begin
                word_now.error = fault;
                return;
            end
        end
        term = (c == csvt_pkg::CH_CR) || (c == csvt_pkg::CH_LF);
        case (mode)
            csvt_pkg::MODE_START:
            begin
                if (term)
                    end_row(c);
                else if (c == csvt_pkg::CH_QUOTE)
                    mode = csvt_pkg::MODE_QUOTED;
                else if (c == csvt_pkg::CH_COMMA)
                    close_field();
                else
                begin
                    mode = csvt_pkg::MODE_PLAIN;
                    append_char(c);
                end
            end
            csvt_pkg::MODE_PLAIN:
            begin
                if (term)
                    end_row(c);
                else if (c == csvt_pkg::CH_COMMA)
                begin
                    close_field();
                    mode = csvt_pkg::MODE_START;
                end
                else
                    append_char(c);
            end
            csvt_pkg::MODE_QUOTED:
            begin
                if (c == csvt_pkg::CH_QUOTE)
                    mode = csvt_pkg::MODE_QUOTE_SEEN;
                else
                    append_char(c);
            end
            default:
            begin
                if (term)
                    end_row(c);
                else if (c == csvt_pkg::CH_QUOTE)
                begin
                    mode = csvt_pkg::MODE_QUOTED;
                    append_char(c);
                end
                else if (c == csvt_pkg::CH_COMMA)
                begin
                    close_field();
                    mode = csvt_pkg::MODE_START;
                end
                else
                begin
                    mode = csvt_pkg::MODE_PLAIN;
                    append_char(c);
                end
            end
        endcase
        word_now.error = fault;
    endfunction

    task automatic check_field(input string name, input logic [30:0] exp_val,
                               input logic [30:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Results are popped before the same-edge input is pushed; latency rules out
    // a word meeting its own result on one edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_words.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word with none expected: expected nothing, actual %h",
                             $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("char_valid", 31'(want.char_valid), 31'(result.char_valid));
                    check_field("char_out",   31'(want.char_out),   31'(result.char_out));
                    check_field("field_done", 31'(want.field_done), 31'(result.field_done));
                    check_field("fld_len",    want.fld_len,         result.fld_len);
                    check_field("row_done",   31'(want.row_done),   31'(result.row_done));
                    check_field("end_done",   31'(want.end_done),   31'(result.end_done));
                    check_field("error",      31'(want.error),      31'(result.error));
                    check_field("row_total",  want.row_total,       result.row_total);
                    check_field("col_total",  want.col_total,       result.col_total);
                    check_field("fld_total",  want.fld_total,       result.fld_total);
                    check_field("byte_total", want.byte_total,      result.byte_total);
                    checked++;
                end
            end
            if (item_valid && !item_stall)
            begin
                tokenize(item);
                expected_words.push_back(word_now);
            end
            pending = expected_words.size();
        end
    end

endmodule

[verif/csv_field_tokenizer_with_stats_core_tb.sv]
// Testbench top for the CSV tokenizer: clock, reset, byte stimulus, idle control, verdict.
module csv_field_tokenizer_with_stats_core_tb;

    localparam int   WORDS_PER_PHASE = 600;
    // Slowest run is ~1800 words under 75% idle or stall; this cycle limit is well
    // over ten times what that run takes.
    localparam int   CYCLE_LIMIT     = 400000;
    localparam logic KIND_BYTE       = 1'b0;
    localparam logic KIND_END        = 1'b1;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    csvt_pkg::in_word_t  item         = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    csvt_pkg::out_word_t result;

    int fail_count;
    int pending;
    int checked;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int words_sent      = 0;
    int buffers_sent    = 0;

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count++;

    csv_field_tokenizer_with_stats_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    csv_token_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // Receiver back-pressure, re-rolled every cycle at the falling edge.
    always @(negedge clk)
        result_stall = ($urandom_range(99) < recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so back-to-back words never drop valid in between.
    task automatic send_word(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid     = 1'b1;
        item.kind      = kind;
        item.data_byte = b;
        do
            @(posedge clk);
        while (item_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(KIND_BYTE, b);
    endtask

    // data_byte is don't-care on the end marker; randomize it anyway.
    task automatic send_end();
        send_word(KIND_END, 8'($urandom));
        buffers_sent++;
    endtask

    // Any byte, with the four structural characters made common.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 30)
        begin
            case ($urandom_range(3))
                0:       return csvt_pkg::CH_QUOTE;
                1:       return csvt_pkg::CH_COMMA;
                2:       return csvt_pkg::CH_CR;
                default: return csvt_pkg::CH_LF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_COMMA ||
               b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF);
        return b;
    endfunction

    // One buffer and its end marker. Mostly well-formed rows of plain, quoted
    // and empty fields with mixed terminators; a share is raw noise, and stray
    // bytes now and then break a row.
    task automatic send_random_buffer();
        int         nrows;
        int         nfields;
        int         len;
        int         style;
        logic [7:0] b;
        if ($urandom_range(99) < 15)
        begin
            len = $urandom_range(0, 20);
            repeat (len)
                send_byte(pick_byte());
        end
        else
        begin
            nrows = $urandom_range(0, 5);
            for (int r = 0; r < nrows; r++)
            begin
                nfields = $urandom_range(1, 5);
                for (int f = 0; f < nfields; f++)
                begin
                    if (f != 0)
                        send_byte(csvt_pkg::CH_COMMA);
                    style = $urandom_range(9);
                    if (style >= 6)
                    begin
                        // quoted: embedded quotes are doubled
                        send_byte(csvt_pkg::CH_QUOTE);
                        len = $urandom_range(0, 6);
                        repeat (len)
                        begin
                            b = pick_byte();
                            send_byte(b);
                            if (b == csvt_pkg::CH_QUOTE)
                                send_byte(csvt_pkg::CH_QUOTE);
                        end
                        send_byte(csvt_pkg::CH_QUOTE);
                    end
                    else if (style >= 2)
                    begin
                        len = $urandom_range(1, 6);
                        repeat (len)
                            send_byte(plain_byte());
                    end
                    if ($urandom_range(99) < 4)
                        send_byte(pick_byte());
                end
                if ($urandom_range(99) < 8)
                    send_byte(csvt_pkg::CH_COMMA);
                // last row is left open half the time
                if (r != nrows - 1 || $urandom_range(1) == 1)
                begin
                    case ($urandom_range(2))
                        0:
                            send_byte(csvt_pkg::CH_LF);
                        1:
                            send_byte(csvt_pkg::CH_CR);
                        default:
                        begin
                            send_byte(csvt_pkg::CH_CR);
                            send_byte(csvt_pkg::CH_LF);
                        end
                    endcase
                end
            end
        end
        send_end();
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results still expected", cycle_count, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        send_idle_pct  = 36;
        recv_stall_pct = 75;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed buffer: byte extremes, quoted comma/CR/LF, doubled quote,
        // CR-LF folding, empty lines, a non-LF after CR, a quote inside a plain
        // field, junk after a closing quote, and a trailing comma before the end.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(csvt_pkg::CH_COMMA);
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte(csvt_pkg::CH_COMMA);
        send_byte(csvt_pkg::CH_CR);
        send_byte(csvt_pkg::CH_LF);
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte(csvt_pkg::CH_CR);
        send_byte(csvt_pkg::CH_LF);
        send_byte(csvt_pkg::CH_LF);
        send_byte(csvt_pkg::CH_CR);
        send_byte("z");
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte(csvt_pkg::CH_CR);
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte("q");
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte("r");
        send_byte(csvt_pkg::CH_COMMA);
        send_end();
        // empty buffer, then a buffer ending inside an open quoted field
        send_end();
        send_byte(csvt_pkg::CH_QUOTE);
        send_byte("k");
        send_end();

        // Three idle mixes: sender-light/receiver-heavy, the reverse, then none.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 75;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 36;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (words_sent < (ph + 1) * WORDS_PER_PHASE)
                send_random_buffer();
        end
        item_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        // three-stage pipe; wait on after the last result to show any stray word
        repeat (8) @(negedge clk);

        $display("Sent %0d words in %0d buffers under three sender/receiver idle mixes.",
                 words_sent, buffers_sent);
        $display("Compared %0d result words, %0d field mismatches.", checked, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/csvt_pkg.sv
sv/csvt_parser.sv
sv/csvt_totals.sv
sv/csv_field_tokenizer_with_stats_core.sv
sv/csvt_checker.sv
verif/csv_token_checker.sv
verif/csv_field_tokenizer_with_stats_core_tb.sv
